[sv/tcpop_pkg.sv]
// ----------------------------------------------------------------------------
// tcpop_pkg
// Shared types and constants for the TCP option area parser.
// ----------------------------------------------------------------------------
package tcpop_pkg;

  // One input beat: a raw option byte plus area start info
  typedef struct packed {
    logic [7:0] opt_byte;
    logic       area_start;
    logic [3:0] header_words;
  } in_beat_t;

  // One result beat
  typedef struct packed {
    logic [3:0]  option_code;
    logic [7:0]  option_length;
    logic [31:0] value_first;
    logic [31:0] value_second;
    logic        parse_done;
  } out_beat_t;

  // Classified entry handed from front to back through the queue
  typedef struct packed {
    logic [7:0] opt_byte;
    logic       area_start;
    logic [5:0] area_len;
  } q_entry_t;

  // Parser phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_KIND = 4'b0010,
    PH_LEN  = 4'b0100,
    PH_BODY = 4'b1000
  } phase_t;

  // Result codes
  localparam logic [3:0] OPT_END       = 4'd0;
  localparam logic [3:0] OPT_NOP       = 4'd1;
  localparam logic [3:0] OPT_MSS       = 4'd2;
  localparam logic [3:0] OPT_WSCALE    = 4'd3;
  localparam logic [3:0] OPT_SACK_OK   = 4'd4;
  localparam logic [3:0] OPT_TSTAMP    = 4'd5;
  localparam logic [3:0] OPT_SACK      = 4'd6;
  localparam logic [3:0] OPT_UNKNOWN   = 4'd7;
  localparam logic [3:0] OPT_MALFORMED = 4'd8;

  // Option kinds on the wire
  localparam logic [7:0] KIND_END     = 8'd0;
  localparam logic [7:0] KIND_NOP     = 8'd1;
  localparam logic [7:0] KIND_MSS     = 8'd2;
  localparam logic [7:0] KIND_WSCALE  = 8'd3;
  localparam logic [7:0] KIND_SACK_OK = 8'd4;
  localparam logic [7:0] KIND_SACK    = 8'd5;
  localparam logic [7:0] KIND_TSTAMP  = 8'd8;

  // Expected lengths of the fixed-size kinds
  localparam logic [7:0] LEN_MSS     = 8'd4;
  localparam logic [7:0] LEN_WSCALE  = 8'd3;
  localparam logic [7:0] LEN_SACK_OK = 8'd2;
  localparam logic [7:0] LEN_TSTAMP  = 8'd10;

  // Fixed TCP header size and its word count
  localparam logic [5:0] BASE_HDR_BYTES = 6'd20;
  localparam logic [3:0] BASE_HDR_WORDS = 4'd5;

endpackage

[sv/tcpop_front.sv]
// ----------------------------------------------------------------------------
// tcpop_front
// Accepts input beats and classifies them: works out the option area
// length from the header word count and pushes an entry to the queue.
// ----------------------------------------------------------------------------
module tcpop_front (
  input  logic                in_valid,
  output logic                in_ready,
  input  tcpop_pkg::in_beat_t in_data,
  output logic                push,
  output tcpop_pkg::q_entry_t push_entry,
  input  logic                q_full
);

  logic [5:0] hdr_bytes;

  // header words times four, less the fixed header; short header means empty
  assign hdr_bytes = {in_data.header_words, 2'b00};

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_entry.opt_byte   = in_data.opt_byte;
    push_entry.area_start = in_data.area_start;
    if (in_data.header_words >= tcpop_pkg::BASE_HDR_WORDS) begin
      push_entry.area_len = hdr_bytes - tcpop_pkg::BASE_HDR_BYTES;
    end else begin
      push_entry.area_len = '0;
    end
  end

endmodule

[sv/tcpop_queue.sv]
// ----------------------------------------------------------------------------
// tcpop_queue
// Short FIFO between the classifier and the parser.
// ----------------------------------------------------------------------------
module tcpop_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tcpop_pkg::q_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                q_valid,
  output tcpop_pkg::q_entry_t q_head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  tcpop_pkg::q_entry_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full    = (count_r == FULL_CNT);
  assign q_valid = (count_r != '0);
  assign q_head  = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

[sv/tcpop_back.sv]
// ----------------------------------------------------------------------------
// tcpop_back
// Option walker: consumes one queued byte per cycle unless the output stalls,
// tracks kind/length tuples, loads completed options to the output register.
// ----------------------------------------------------------------------------
module tcpop_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  tcpop_pkg::q_entry_t  q_head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tcpop_pkg::out_beat_t out_data
);

  tcpop_pkg::phase_t phase_r, phase_nxt, ph_e;
  logic [5:0]  bl_r, bl_nxt, bl_e;
  logic [7:0]  kind_r, kind_nxt, kind_e;
  logic [7:0]  len_r, len_nxt, len_e;
  logic [5:0]  pos_r, pos_nxt, pos_e;
  logic [31:0] acc1_r, acc1_nxt, acc1_e;
  logic [31:0] acc2_r, acc2_nxt, acc2_e;
  logic        out_valid_r, out_valid_nxt;
  tcpop_pkg::out_beat_t out_data_r, res;
  logic        emit, do_finish, fin_done;
  logic [7:0]  b;

  assign b         = q_head.opt_byte;
  assign pop       = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // parser step for the head entry
  always_comb begin
    // area start overrides the walk state
    ph_e   = phase_r;
    bl_e   = bl_r;
    kind_e = kind_r;
    len_e  = len_r;
    pos_e  = pos_r;
    acc1_e = acc1_r;
    acc2_e = acc2_r;
    if (q_head.area_start) begin
      bl_e   = q_head.area_len;
      ph_e   = (q_head.area_len != '0) ? tcpop_pkg::PH_KIND : tcpop_pkg::PH_IDLE;
      kind_e = '0;
      len_e  = '0;
      pos_e  = '0;
      acc1_e = '0;
      acc2_e = '0;
    end

    phase_nxt = ph_e;
    bl_nxt    = bl_e;
    kind_nxt  = kind_e;
    len_nxt   = len_e;
    pos_nxt   = pos_e;
    acc1_nxt  = acc1_e;
    acc2_nxt  = acc2_e;
    emit      = 1'b0;
    do_finish = 1'b0;
    res       = '0;

    if (ph_e == tcpop_pkg::PH_IDLE || bl_e == '0) begin
      phase_nxt = tcpop_pkg::PH_IDLE;
    end else begin
      unique case (ph_e)
        tcpop_pkg::PH_KIND: begin
          if (b == tcpop_pkg::KIND_END) begin
            phase_nxt        = tcpop_pkg::PH_IDLE;
            bl_nxt           = '0;
            emit             = 1'b1;
            res.option_code  = tcpop_pkg::OPT_END;
            res.parse_done   = 1'b1;
          end else if (b == tcpop_pkg::KIND_NOP) begin
            bl_nxt             = bl_e - 1'b1;
            phase_nxt          = (bl_nxt == '0) ? tcpop_pkg::PH_IDLE : tcpop_pkg::PH_KIND;
            emit               = 1'b1;
            res.option_code    = tcpop_pkg::OPT_NOP;
            res.option_length  = 8'd1;
            res.parse_done     = (bl_nxt == '0);
          end else if (bl_e < 6'd2) begin
            // kind on the last area byte: no room for a length
            phase_nxt          = tcpop_pkg::PH_IDLE;
            bl_nxt             = '0;
            emit               = 1'b1;
            res.option_code    = tcpop_pkg::OPT_MALFORMED;
            res.value_first    = {24'd0, b};
            res.parse_done     = 1'b1;
          end else begin
            kind_nxt  = b;
            bl_nxt    = bl_e - 1'b1;
            phase_nxt = tcpop_pkg::PH_LEN;
          end
        end
        tcpop_pkg::PH_LEN: begin
          if (b < 8'd2 || {1'b0, b} > ({3'd0, bl_e} + 9'd1)) begin
            phase_nxt          = tcpop_pkg::PH_IDLE;
            bl_nxt             = '0;
            emit               = 1'b1;
            res.option_code    = tcpop_pkg::OPT_MALFORMED;
            res.option_length  = b;
            res.value_first    = {24'd0, kind_e};
            res.parse_done     = 1'b1;
          end else begin
            len_nxt  = b;
            bl_nxt   = bl_e - 1'b1;
            pos_nxt  = '0;
            acc1_nxt = '0;
            acc2_nxt = '0;
            if (b == 8'd2) begin
              do_finish = 1'b1;
            end else begin
              phase_nxt = tcpop_pkg::PH_BODY;
            end
          end
        end
        tcpop_pkg::PH_BODY: begin
          // only the first eight body bytes are kept
          if (pos_e < 6'd4) begin
            acc1_nxt = {acc1_e[23:0], b};
          end else if (pos_e < 6'd8) begin
            acc2_nxt = {acc2_e[23:0], b};
          end
          pos_nxt = pos_e + 1'b1;
          bl_nxt  = bl_e - 1'b1;
          if (({3'd0, pos_nxt} + 9'd2) >= {1'b0, len_e}) begin
            do_finish = 1'b1;
          end
        end
        default: begin
          phase_nxt = tcpop_pkg::PH_IDLE;
        end
      endcase
    end

    // option complete: report fixed-size kinds only at their expected length
    fin_done = (bl_nxt == '0);
    if (do_finish) begin
      phase_nxt      = fin_done ? tcpop_pkg::PH_IDLE : tcpop_pkg::PH_KIND;
      res            = '0;
      res.option_length = len_nxt;
      res.parse_done = fin_done;
      case (kind_nxt)
        tcpop_pkg::KIND_MSS: begin
          emit            = (len_nxt == tcpop_pkg::LEN_MSS);
          res.option_code = tcpop_pkg::OPT_MSS;
          res.value_first = {16'd0, acc1_nxt[15:0]};
        end
        tcpop_pkg::KIND_WSCALE: begin
          emit            = (len_nxt == tcpop_pkg::LEN_WSCALE);
          res.option_code = tcpop_pkg::OPT_WSCALE;
          res.value_first = {24'd0, acc1_nxt[7:0]};
        end
        tcpop_pkg::KIND_SACK_OK: begin
          emit            = (len_nxt == tcpop_pkg::LEN_SACK_OK);
          res.option_code = tcpop_pkg::OPT_SACK_OK;
        end
        tcpop_pkg::KIND_TSTAMP: begin
          emit             = (len_nxt == tcpop_pkg::LEN_TSTAMP);
          res.option_code  = tcpop_pkg::OPT_TSTAMP;
          res.value_first  = acc1_nxt;
          res.value_second = acc2_nxt;
        end
        tcpop_pkg::KIND_SACK: begin
          emit            = 1'b1;
          res.option_code = tcpop_pkg::OPT_SACK;
        end
        default: begin
          emit            = 1'b1;
          res.option_code = tcpop_pkg::OPT_UNKNOWN;
          res.value_first = {24'd0, kind_nxt};
        end
      endcase
    end

    // output register: load on a result, drain when taken
    out_valid_nxt = out_valid_r;
    if (pop && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // walk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= tcpop_pkg::PH_IDLE;
      bl_r        <= '0;
      kind_r      <= '0;
      len_r       <= '0;
      pos_r       <= '0;
      acc1_r      <= '0;
      acc2_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        phase_r <= phase_nxt;
        bl_r    <= bl_nxt;
        kind_r  <= kind_nxt;
        len_r   <= len_nxt;
        pos_r   <= pos_nxt;
        acc1_r  <= acc1_nxt;
        acc2_r  <= acc2_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_data_r <= res;
    end
  end

endmodule

[sv/tcp_option_parser_unit.sv]
// ----------------------------------------------------------------------------
// tcp_option_parser_unit
// A beat's entry is written to the queue; the walker pops it and, for a
// result, loads the output register that drives out_valid.
// Throughput: one option byte per cycle unless the output stalls, set by
// the single-byte walker step. The queue between classifier and walker
// absorbs output stalls. Reset (rst_n low, synchronous) empties the queue
// and returns the walker to idle with no pending result.
// ----------------------------------------------------------------------------
module tcp_option_parser_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tcpop_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tcpop_pkg::out_beat_t out_data
);

  logic                push, pop, q_full, q_valid;
  tcpop_pkg::q_entry_t push_entry, q_head;

  // classifier
  tcpop_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push       (push),
    .push_entry (push_entry),
    .q_full     (q_full)
  );

  // decoupling queue
  tcpop_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_head     (q_head)
  );

  // option walker and output register
  tcpop_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
